FILE: src/fol_pkg.sv
// fol_pkg: shared types and codes for the frequency ordered list
// no dependencies; used by the cell, the top level, the checker and the testbench
package fol_pkg;

  localparam int ValueW  = 32;
  localparam int KindW   = 2;
  localparam int StatusW = 2;
  localparam int PosW    = 4;
  localparam int CountW  = 16;

  localparam logic [KindW-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KindW-1:0] KIND_ACCESS = 2'd1;
  localparam logic [KindW-1:0] KIND_DUMP   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_MISS  = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SEL   = 6'b000100,
    S_BLOCK = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DUMP  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic place;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: src/fol_cell.sv
// fol_cell: one list entry (value, count, rank) with its compare logic
// depends on fol_pkg
module fol_cell import fol_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int RANK_BITS  = 5
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic                  used,
  input  logic [ValueW-1:0]     key,
  input  logic [COUNT_BITS-1:0] cmp_count,
  input  logic [RANK_BITS-1:0]  cmp_rank,
  input  logic [ValueW-1:0]     left_value,
  input  logic [COUNT_BITS-1:0] left_count,
  input  logic [RANK_BITS-1:0]  left_rank,
  output logic [ValueW-1:0]     value_q,
  output logic [COUNT_BITS-1:0] count_q,
  output logic [RANK_BITS-1:0]  rank_q,
  output logic                  match,
  output logic                  beat
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value_q <= key;
      count_q <= '0;
      rank_q  <= '0;
    end else if (ctrl.place) begin
      value_q <= key;
      count_q <= cmp_count;
      rank_q  <= cmp_rank;
    end else if (ctrl.shift) begin
      value_q <= left_value;
      count_q <= left_count;
      rank_q  <= left_rank;
    end
  end

  assign match = used && (value_q == key);
  assign beat  = (count_q > cmp_count) || ((count_q == cmp_count) && (rank_q < cmp_rank));

endmodule

FILE: src/frequency_ordered_list.sv
// frequency_ordered_list: self-organising list, frequency-count ordering, row of fol_cell
// depends on fol_pkg and fol_cell
// result paths: load S_LOAD; hit S_SEL, S_BLOCK, S_SHIFT; miss S_SEL; dump one per entry
// one word at a time: next word accepted the cycle after its last result is registered
// access cost set by the compare, first-match select, blocker search and shift steps
// synchronous reset empties the list and sets the next rank to one; entries are not cleared
module frequency_ordered_list import fol_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KindW-1:0]   kind,
  input  logic signed [ValueW-1:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [StatusW-1:0] status,
  output logic [PosW-1:0]    position,
  output logic signed [ValueW-1:0] entry_value,
  output logic [CountW-1:0]  count,
  output logic               last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(DEPTH + 2);

  state_t                state;
  logic [UW-1:0]         used;
  logic [RW-1:0]         next_rank;
  logic [ValueW-1:0]     key_r;
  logic [DEPTH-1:0]      match_r;
  logic [DEPTH-1:0]      sel_r;
  logic [DEPTH-1:0]      blk_r;
  logic [COUNT_BITS-1:0] c_new;
  logic [RW-1:0]         r_new;
  logic                  fresh;
  logic [IW-1:0]         idx;

  logic [ValueW-1:0]     key;
  logic [ValueW-1:0]     cv [DEPTH];
  logic [COUNT_BITS-1:0] cc [DEPTH];
  logic [RW-1:0]         cr [DEPTH];
  logic [ValueW-1:0]     lv [DEPTH];
  logic [COUNT_BITS-1:0] lc [DEPTH];
  logic [RW-1:0]         lr [DEPTH];
  logic [DEPTH-1:0]      cm;
  logic [DEPTH-1:0]      cb;
  logic [DEPTH-1:0]      cuse;
  cell_ctrl_t            ctrl [DEPTH];

  logic                  accept;
  logic                  out_free;
  logic [DEPTH-1:0]      sel;
  logic [COUNT_BITS-1:0] c_old;
  logic [RW-1:0]         r_old;
  logic [DEPTH-1:0]      bm;
  logic [DEPTH-1:0]      rev;
  logic [DEPTH-1:0]      rh;
  logic [DEPTH-1:0]      h;
  logic [DEPTH-1:0]      lowmask;
  logic [DEPTH-1:0]      win;
  logic [DEPTH-1:0]      dsth;
  logic [IW-1:0]         dst_idx;
  logic                  dump_last;

  logic                  emit;
  logic [StatusW-1:0]    e_status;
  logic [IW-1:0]         e_index;
  logic [ValueW-1:0]     e_value;
  logic [COUNT_BITS-1:0] e_count;
  logic [PosW-1:0]       e_pos;
  logic [CountW-1:0]     e_cnt;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign key      = (state == S_IDLE) ? value : key_r;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign lv[j] = '0;
      assign lc[j] = '0;
      assign lr[j] = '0;
    end else begin : g_body
      assign lv[j] = cv[j-1];
      assign lc[j] = cc[j-1];
      assign lr[j] = cr[j-1];
    end
    assign cuse[j] = (UW'(j) < used);

    fol_cell #(.COUNT_BITS(COUNT_BITS), .RANK_BITS(RW)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[j]),
      .used       (cuse[j]),
      .key        (key),
      .cmp_count  (c_new),
      .cmp_rank   (r_new),
      .left_value (lv[j]),
      .left_count (lc[j]),
      .left_rank  (lr[j]),
      .value_q    (cv[j]),
      .count_q    (cc[j]),
      .rank_q     (cr[j]),
      .match      (cm[j]),
      .beat       (cb[j])
    );
  end

  // first match and its stored count and rank
  always_comb begin
    sel   = match_r & (~match_r + 1'b1);
    c_old = '0;
    r_old = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (sel[j]) begin
        c_old = c_old | cc[j];
        r_old = r_old | cr[j];
      end
    end
  end

  // nearest blocker ahead of the found entry
  always_comb begin
    bm = cb & (sel_r - 1'b1);
    for (int j = 0; j < DEPTH; j++) begin
      rev[j] = bm[DEPTH-1-j];
    end
    rh = rev & (~rev + 1'b1);
    for (int j = 0; j < DEPTH; j++) begin
      h[j] = rh[DEPTH-1-j];
    end
  end

  // shift window and destination
  always_comb begin
    lowmask = (blk_r == '0) ? '0 : (blk_r | (blk_r - 1'b1));
    win     = (sel_r | (sel_r - 1'b1)) & ~lowmask;
    dsth    = (blk_r == '0) ? DEPTH'(1) : (blk_r << 1);
    dst_idx = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (dsth[j]) begin
        dst_idx = dst_idx | IW'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      ctrl[j].load  = (state == S_LOAD) && out_free && (used != UW'(DEPTH)) &&
                      (UW'(j) == used);
      ctrl[j].place = (state == S_SHIFT) && out_free && dsth[j];
      ctrl[j].shift = (state == S_SHIFT) && out_free && win[j] && !dsth[j];
    end
  end

  assign dump_last = ((UW'(idx) + 1'b1) == used);

  always_comb begin
    emit     = 1'b0;
    e_status = ST_OK;
    e_index  = '0;
    e_value  = '0;
    e_count  = '0;
    case (state)
      S_LOAD: begin
        emit = out_free;
        if (used == UW'(DEPTH)) begin
          e_status = ST_FULL;
        end else begin
          e_index = used[IW-1:0];
          e_value = key_r;
        end
      end
      S_SEL: begin
        if (match_r == '0) begin
          emit     = out_free;
          e_status = ST_MISS;
        end
      end
      S_SHIFT: begin
        emit    = out_free;
        e_index = dst_idx;
        e_value = key_r;
        e_count = c_new;
      end
      S_DUMP: begin
        emit = out_free;
        if (used == '0) begin
          e_status = ST_EMPTY;
        end else begin
          e_index = idx;
          e_value = cv[idx];
          e_count = cc[idx];
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  if (IW >= PosW) begin : g_pos_cut
    assign e_pos = e_index[PosW-1:0];
  end else begin : g_pos_ext
    assign e_pos = {{(PosW-IW){1'b0}}, e_index};
  end

  if (COUNT_BITS >= CountW) begin : g_cnt_cut
    assign e_cnt = e_count[CountW-1:0];
  end else begin : g_cnt_ext
    assign e_cnt = {{(CountW-COUNT_BITS){1'b0}}, e_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      next_rank <= RW'(1);
      idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_LOAD:   state <= S_LOAD;
              KIND_ACCESS: state <= S_SEL;
              KIND_DUMP:   state <= S_DUMP;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          if (out_free) begin
            if (used != UW'(DEPTH)) begin
              used <= used + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_SEL: begin
          if (match_r != '0) begin
            state <= S_BLOCK;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_BLOCK: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (out_free) begin
            if (fresh) begin
              next_rank <= next_rank + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            if (used == '0 || dump_last) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= value;
      match_r <= cm;
    end
    if (state == S_SEL) begin
      sel_r <= sel;
      c_new <= (c_old == '1) ? c_old : c_old + 1'b1;
      r_new <= (r_old == '0) ? next_rank : r_old;
      fresh <= (r_old == '0);
    end
    if (state == S_BLOCK) begin
      blk_r <= h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= e_status;
      position    <= e_pos;
      entry_value <= e_value;
      count       <= e_cnt;
      last        <= (state != S_DUMP) || (used == '0) || dump_last;
    end
  end

endmodule

FILE: src/fol_checker.sv
// fol_checker: port-level assertions for frequency_ordered_list, bound to the top level
// depends on fol_pkg
module fol_checker import fol_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [KindW-1:0]   kind,
  input logic [ValueW-1:0]  value,
  input logic               out_valid,
  input logic               out_stall,
  input logic [StatusW-1:0] status,
  input logic [PosW-1:0]    position,
  input logic [ValueW-1:0]  entry_value,
  input logic [CountW-1:0]  count,
  input logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(position) &&
      $stable(entry_value) && $stable(count) && $stable(last))
    else $error("stalled result word changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (position == '0) && (entry_value == '0) &&
      (count == '0))
    else $error("error result carries data");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == KIND_LOAD || kind == KIND_ACCESS ||
      kind == KIND_DUMP) |=> in_stall)
    else $error("input taken while a word is in progress");

endmodule

bind frequency_ordered_list fol_checker u_fol_checker (.*);

FILE: tb/testbench.sv
// testbench: checks frequency_ordered_list against a behavioural list kept in a scoreboard class
// depends on fol_pkg and frequency_ordered_list; directed words, random phases, full list
module testbench;
  import fol_pkg::*;

  localparam int ListDepth = 16;
  localparam int CountBits = 16;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] entry_value;
    logic [CountW-1:0]        count;
    logic                     last;
  } list_reply_t;

  class list_tracker;
    logic signed [ValueW-1:0] item_val [ListDepth];
    logic [CountW-1:0]        item_hits [ListDepth];
    int unsigned              item_order [ListDepth];
    int unsigned              fill;
    int unsigned              order_next;
    list_reply_t              pending [$];
    int unsigned              errors;

    function new();
      fill = 0;
      order_next = 1;
      errors = 0;
    endfunction

    function void queue_reply(logic [StatusW-1:0] st, int unsigned pos,
                              logic signed [ValueW-1:0] v, logic [CountW-1:0] c,
                              logic lst);
      list_reply_t r;
      r.status = st;
      r.position = PosW'(pos);
      r.entry_value = v;
      r.count = c;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void note_request(logic [KindW-1:0] k, logic signed [ValueW-1:0] v);
      int found;
      int unsigned dst;
      logic [CountW-1:0] c;
      int unsigned r;
      found = -1;
      dst = 0;
      case (k)
        KIND_LOAD: begin
          if (fill >= ListDepth) begin
            queue_reply(ST_FULL, 0, '0, '0, 1'b1);
          end else begin
            item_val[fill] = v;
            item_hits[fill] = '0;
            item_order[fill] = 0;
            queue_reply(ST_OK, fill, v, '0, 1'b1);
            fill++;
          end
        end
        KIND_ACCESS: begin
          for (int i = 0; i < int'(fill); i++) begin
            if (item_val[i] == v) begin
              found = i;
              break;
            end
          end
          if (found < 0) begin
            queue_reply(ST_MISS, 0, '0, '0, 1'b1);
          end else begin
            c = item_hits[found];
            if (c != CountMax) c++;
            r = item_order[found];
            if (r == 0) begin
              r = order_next;
              order_next++;
            end
            // stay behind the nearest entry with more hits, or equal hits and earlier rank
            for (int i = found; i > 0; i--) begin
              if (item_hits[i-1] > c || (item_hits[i-1] == c && item_order[i-1] < r)) begin
                dst = i;
                break;
              end
            end
            for (int i = found; i > int'(dst); i--) begin
              item_val[i] = item_val[i-1];
              item_hits[i] = item_hits[i-1];
              item_order[i] = item_order[i-1];
            end
            item_val[dst] = v;
            item_hits[dst] = c;
            item_order[dst] = r;
            queue_reply(ST_OK, dst, v, c, 1'b1);
          end
        end
        KIND_DUMP: begin
          if (fill == 0) begin
            queue_reply(ST_EMPTY, 0, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              queue_reply(ST_OK, i, item_val[i], item_hits[i], i + 1 == fill);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(list_reply_t got);
      list_reply_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = pending.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("position", 64'(want.position), 64'(got.position));
        compare_field("entry_value", 64'(unsigned'(want.entry_value)),
                      64'(unsigned'(got.entry_value)));
        compare_field("count", 64'(want.count), 64'(got.count));
        compare_field("last", 64'(want.last), 64'(got.last));
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KindW-1:0]         kind = KIND_LOAD;
  logic signed [ValueW-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [StatusW-1:0]       status;
  logic [PosW-1:0]          position;
  logic signed [ValueW-1:0] entry_value;
  logic [CountW-1:0]        count;
  logic                     last;

  list_tracker tracker = new();
  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  list_reply_t seen_reply;

  frequency_ordered_list #(
    .DEPTH(ListDepth),
    .COUNT_BITS(CountBits)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .position(position),
    .entry_value(entry_value),
    .count(count),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_reply = {status, position, entry_value, count, last};
        tracker.check_reply(seen_reply);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // valid is left high after a word is taken so back-to-back words need no gap
  task automatic send_word(logic [KindW-1:0] k, logic signed [ValueW-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    do @(posedge clk); while (in_stall);
    tracker.note_request(k, v);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_word();
    int unsigned pick;
    int unsigned load_cut;
    logic [KindW-1:0] k;
    logic signed [ValueW-1:0] v;
    pick = $urandom_range(99);
    v = $urandom;
    load_cut = (tracker.fill < ListDepth) ? 45 : 18;
    if (pick < 3) begin
      k = KIND_UNUSED;
    end else if (pick < 10) begin
      k = KIND_DUMP;
    end else if (pick < load_cut) begin
      k = KIND_LOAD;
      if ($urandom_range(3) == 0 && tracker.fill > 0)
        v = tracker.item_val[$urandom_range(tracker.fill - 1)];
    end else begin
      k = KIND_ACCESS;
      if ($urandom_range(9) < 8 && tracker.fill > 0)
        v = tracker.item_val[$urandom_range(tracker.fill - 1)];
    end
    send_word(k, v);
  endtask

  initial begin : stimulus
    int unsigned idle_plan [4] = '{0, 70, 0, 32};
    int unsigned stall_plan [4] = '{0, 0, 70, 32};
    logic signed [ValueW-1:0] hot;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, extremes, duplicates, ties and misses
    send_word(KIND_DUMP, 32'sd7);
    send_word(KIND_ACCESS, 32'sd5);
    send_word(KIND_UNUSED, -32'sd1);
    send_word(KIND_LOAD, 32'sh8000_0000);
    send_word(KIND_LOAD, 32'sh7fff_ffff);
    send_word(KIND_LOAD, 32'sd0);
    send_word(KIND_LOAD, -32'sd1);
    send_word(KIND_LOAD, 32'sh7fff_ffff);
    send_word(KIND_ACCESS, 32'sd0);
    send_word(KIND_ACCESS, -32'sd1);
    send_word(KIND_ACCESS, -32'sd1);
    send_word(KIND_ACCESS, 32'sh7fff_ffff);
    send_word(KIND_ACCESS, 32'sh8000_0000);
    send_word(KIND_ACCESS, 32'sh0000_1234);
    send_word(KIND_LOAD, 32'sh5555_5555);
    send_word(KIND_LOAD, 32'shaaaa_aaaa);
    send_word(KIND_ACCESS, 32'shaaaa_aaaa);
    send_word(KIND_DUMP, 32'sh5a5a_5a5a);

    for (int p = 0; p < 4; p++) begin
      drain_replies();
      send_idle = idle_plan[p];
      stall_pct = stall_plan[p];
      for (int n = 0; n < 100; n++) begin
        random_word();
        if ($urandom_range(49) == 0) drain_replies();
      end
    end

    // fill the list, overflow it, then keep accessing the tail entry
    drain_replies();
    send_idle = 0;
    stall_pct = 0;
    while (tracker.fill < ListDepth) send_word(KIND_LOAD, $urandom);
    send_word(KIND_LOAD, $urandom);
    hot = tracker.item_val[ListDepth - 1];
    repeat (16) send_word(KIND_ACCESS, hot);
    send_word(KIND_DUMP, 32'sd0);

    drain_replies();
    send_idle = 32;
    stall_pct = 32;
    repeat (20) random_word();

    drain_replies();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
